// ===== hdl/lrfb_pkg.sv =====
// Shared types and constants of the line raster framebuffer.
// No dependencies; the top level and its checker import it.
`default_nettype none

package lrfb_pkg;

  // Command codes carried on in_kind
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Nibble masks for the packed store: even pixel high, odd pixel low
  localparam logic [7:0] NIB_HI_MASK = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0f;

  typedef logic signed [15:0] coord_t;   // screen coordinate as given
  typedef logic        [15:0] span_t;    // absolute axis difference
  typedef logic signed [19:0] dec_t;     // Bresenham decision variable
  typedef logic        [16:0] cnt_t;     // pixels written by one command

  // Longest line covers 65536 points
  localparam cnt_t MAX_PIXELS = 17'h10000;

endpackage

`default_nettype wire

// ===== hdl/lrfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 38400
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/line_raster_framebuffer.sv =====
// Line raster framebuffer: 4-bit pixel store with a Bresenham line walker.
// Depends on lrfb_pkg and lrfb_ram.
//
// The block keeps a DISPLAY_WIDTH x DISPLAY_HEIGHT framebuffer of 4-bit pixels
// packed two per byte (pixel y*DISPLAY_WIDTH+x, even pixel in the high nibble)
// in one RAM. Each request (draw line, set pixel, read byte, clear) gives one
// result with the read byte (zero unless a read) and the count of on-screen
// pixels written. Off-screen pixels are dropped and not counted. One request
// is worked at a time; in_stall stays high until it is finished, but a new
// request is taken while the previous result still waits on out_stall.
// Steps: a line takes accept, four setup steps and result handoff, plus index,
// RAM read and RAM read-modify-write for each on-screen pixel and only the index
// step for each clipped pixel, all on the single RAM port pair and one shared
// step datapath. Set pixel skips the setup. A read of an address past the store
// skips the RAM read. Clear sweeps all (W*H+1)/2 bytes of the RAM one byte per
// cycle. After reset the same clearing pass runs with in_stall high. A stalled
// result holds back the handoff of the result after it.
`default_nettype none

module line_raster_framebuffer #(
  parameter int DISPLAY_WIDTH  = 320,
  parameter int DISPLAY_HEIGHT = 240
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_kind,
  input  wire lrfb_pkg::coord_t     in_start_x,
  input  wire lrfb_pkg::coord_t     in_start_y,
  input  wire lrfb_pkg::coord_t     in_end_x,
  input  wire lrfb_pkg::coord_t     in_end_y,
  input  wire logic [3:0]           in_pixel_color,
  input  wire logic [15:0]          in_byte_address,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_read_data,
  output lrfb_pkg::cnt_t            out_pixels_drawn
);

  import lrfb_pkg::*;

  localparam int STORE_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT + 1) / 2;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IDX_W       = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,   // sweep the store with zeros
    S_IDLE,    // wait for a request
    S_DIFF,    // absolute axis differences
    S_ORIENT,  // pick the major axis and the start endpoint
    S_INIT,    // major span, minor span and minor direction
    S_PREP,    // decision start and increments
    S_STEP,    // bounds check, pixel index, Bresenham advance
    S_READ,    // read the byte holding the pixel
    S_MERGE,   // write the byte back with the new nibble
    S_RDADDR,  // read request: address the store
    S_RDDATA,  // read request: capture the byte
    S_DONE     // hand the result to the output register
  } state_t;

  state_t            state_r,          state_nxt;
  logic              clr_cmd_r,        clr_cmd_nxt;
  logic [ADDR_W-1:0] clr_addr_r,       clr_addr_nxt;
  logic              out_valid_r,      out_valid_nxt;
  logic [7:0]        out_read_data_r,  out_read_data_nxt;
  cnt_t              out_pixels_r,     out_pixels_nxt;

  coord_t            sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [3:0]        color_r,          color_nxt;
  logic [15:0]       baddr_r,          baddr_nxt;
  span_t             adx_r,            adx_nxt;
  span_t             ady_r,            ady_nxt;
  logic              transpose_r,      transpose_nxt;
  coord_t            a_r,              a_nxt;
  coord_t            b_r,              b_nxt;
  coord_t            a_end_r,          a_end_nxt;
  coord_t            b_end_r,          b_end_nxt;
  span_t             da_r,             da_nxt;
  span_t             db_r,             db_nxt;
  logic              step_neg_r,       step_neg_nxt;
  dec_t              d_r,              d_nxt;
  dec_t              inc_step_r,       inc_step_nxt;
  dec_t              inc_flat_r,       inc_flat_nxt;
  span_t             left_r,           left_nxt;
  logic              last_r,           last_nxt;
  logic [IDX_W-1:0]  pix_idx_r,        pix_idx_nxt;
  cnt_t              cnt_r,            cnt_nxt;
  logic [7:0]        rd_data_r,        rd_data_nxt;

  // RAM port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Datapath helpers
  logic signed [16:0] dx_w, dy_w, dmaj_w, dmin_w;
  coord_t             px_w, py_w;
  logic               on_screen_w;
  logic [31:0]        idx_w;
  logic [ADDR_W-1:0]  pix_byte_w;
  logic [31:0]        baddr_ext_w;
  logic [7:0]         merged_w;

  lrfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_pixels_drawn = out_pixels_r;

  // Endpoint differences, widened by one bit so they never wrap
  assign dx_w   = {ex_r[15], ex_r} - {sx_r[15], sx_r};
  assign dy_w   = {ey_r[15], ey_r} - {sy_r[15], sy_r};
  assign dmaj_w = {a_end_r[15], a_end_r} - {a_r[15], a_r};
  assign dmin_w = {b_end_r[15], b_end_r} - {b_r[15], b_r};

  // Current point in screen terms; a is the row when the line is y-major
  assign px_w = transpose_r ? b_r : a_r;
  assign py_w = transpose_r ? a_r : b_r;
  assign on_screen_w = !px_w[15] && !py_w[15]
                    && ($unsigned(px_w) < 16'(DISPLAY_WIDTH))
                    && ($unsigned(py_w) < 16'(DISPLAY_HEIGHT));
  assign idx_w = 32'($unsigned(py_w)) * 32'(DISPLAY_WIDTH) + 32'($unsigned(px_w));

  assign pix_byte_w  = ADDR_W'(pix_idx_r >> 1);
  assign baddr_ext_w = 32'(baddr_r);

  // Replace one nibble of the stored byte
  assign merged_w = pix_idx_r[0]
                  ? ((ram_rdata & NIB_HI_MASK) | {4'h0, color_r})
                  : ((ram_rdata & NIB_LO_MASK) | {color_r, 4'h0});

  always_comb begin
    state_nxt         = state_r;
    clr_cmd_nxt       = clr_cmd_r;
    clr_addr_nxt      = clr_addr_r;
    out_read_data_nxt = out_read_data_r;
    out_pixels_nxt    = out_pixels_r;
    sx_nxt            = sx_r;
    sy_nxt            = sy_r;
    ex_nxt            = ex_r;
    ey_nxt            = ey_r;
    color_nxt         = color_r;
    baddr_nxt         = baddr_r;
    adx_nxt           = adx_r;
    ady_nxt           = ady_r;
    transpose_nxt     = transpose_r;
    a_nxt             = a_r;
    b_nxt             = b_r;
    a_end_nxt         = a_end_r;
    b_end_nxt         = b_end_r;
    da_nxt            = da_r;
    db_nxt            = db_r;
    step_neg_nxt      = step_neg_r;
    d_nxt             = d_r;
    inc_step_nxt      = inc_step_r;
    inc_flat_nxt      = inc_flat_r;
    left_nxt          = left_r;
    last_nxt          = last_r;
    pix_idx_nxt       = pix_idx_r;
    cnt_nxt           = cnt_r;
    rd_data_nxt       = rd_data_r;

    ram_we    = 1'b0;
    ram_waddr = pix_byte_w;
    ram_wdata = merged_w;
    ram_re    = 1'b0;
    ram_raddr = pix_byte_w;

    // Drop the held result once the consumer takes it
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = 8'h00;
        if (clr_addr_r == LAST_BYTE) begin
          clr_addr_nxt = '0;
          clr_cmd_nxt  = 1'b0;
          // A clear request reports; the clearing pass after reset does not
          state_nxt    = clr_cmd_r ? S_DONE : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          sx_nxt      = in_start_x;
          sy_nxt      = in_start_y;
          ex_nxt      = in_end_x;
          ey_nxt      = in_end_y;
          color_nxt   = in_pixel_color;
          baddr_nxt   = in_byte_address;
          cnt_nxt     = '0;
          rd_data_nxt = 8'h00;
          case (in_kind)
            KIND_LINE:  state_nxt = S_DIFF;
            KIND_PIXEL: begin
              // A single point: walk of one step, x as the major axis
              a_nxt         = in_start_x;
              b_nxt         = in_start_y;
              transpose_nxt = 1'b0;
              left_nxt      = '0;
              state_nxt     = S_STEP;
            end
            KIND_READ:  state_nxt = S_RDADDR;
            KIND_CLEAR: begin
              clr_cmd_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            default:    state_nxt = S_IDLE;
          endcase
        end
      end

      S_DIFF: begin
        adx_nxt   = dx_w[16] ? span_t'(-dx_w) : dx_w[15:0];
        ady_nxt   = dy_w[16] ? span_t'(-dy_w) : dy_w[15:0];
        state_nxt = S_ORIENT;
      end

      S_ORIENT: begin
        if (ady_r < adx_r) begin
          // x-major, run from the smaller x
          transpose_nxt = 1'b0;
          if (sx_r > ex_r) begin
            a_nxt = ex_r;  b_nxt = ey_r;  a_end_nxt = sx_r;  b_end_nxt = sy_r;
          end else begin
            a_nxt = sx_r;  b_nxt = sy_r;  a_end_nxt = ex_r;  b_end_nxt = ey_r;
          end
        end else begin
          // y-major (ties and single points too), run from the smaller y
          transpose_nxt = 1'b1;
          if (sy_r > ey_r) begin
            a_nxt = ey_r;  b_nxt = ex_r;  a_end_nxt = sy_r;  b_end_nxt = sx_r;
          end else begin
            a_nxt = sy_r;  b_nxt = sx_r;  a_end_nxt = ey_r;  b_end_nxt = ex_r;
          end
        end
        state_nxt = S_INIT;
      end

      S_INIT: begin
        da_nxt       = dmaj_w[15:0];
        step_neg_nxt = dmin_w[16];
        db_nxt       = dmin_w[16] ? span_t'(-dmin_w) : dmin_w[15:0];
        left_nxt     = dmaj_w[15:0];
        state_nxt    = S_PREP;
      end

      S_PREP: begin
        inc_flat_nxt = $signed({3'b000, db_r, 1'b0});
        inc_step_nxt = $signed({3'b000, db_r, 1'b0}) - $signed({3'b000, da_r, 1'b0});
        d_nxt        = $signed({3'b000, db_r, 1'b0}) - $signed({4'b0000, da_r});
        state_nxt    = S_STEP;
      end

      S_STEP: begin
        pix_idx_nxt = idx_w[IDX_W-1:0];
        last_nxt    = (left_r == '0);
        left_nxt    = left_r - 1'b1;
        a_nxt       = a_r + 16'sd1;
        if (d_r > 20'sd0) begin
          b_nxt = step_neg_r ? (b_r - 16'sd1) : (b_r + 16'sd1);
          d_nxt = d_r + inc_step_r;
        end else begin
          d_nxt = d_r + inc_flat_r;
        end
        if (on_screen_w) begin
          state_nxt = S_READ;
        end else if (left_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_STEP;
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_MERGE;
      end

      S_MERGE: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? S_DONE : S_STEP;
      end

      S_RDADDR: begin
        // Out-of-range addresses read as zero
        if (baddr_ext_w < 32'(STORE_BYTES)) begin
          ram_re    = 1'b1;
          ram_raddr = baddr_ext_w[ADDR_W-1:0];
          state_nxt = S_RDDATA;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RDDATA: begin
        rd_data_nxt = ram_rdata;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_read_data_nxt = rd_data_r;
          out_pixels_nxt    = cnt_r;
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_read_data_r <= out_read_data_nxt;
    out_pixels_r    <= out_pixels_nxt;
    sx_r            <= sx_nxt;
    sy_r            <= sy_nxt;
    ex_r            <= ex_nxt;
    ey_r            <= ey_nxt;
    color_r         <= color_nxt;
    baddr_r         <= baddr_nxt;
    adx_r           <= adx_nxt;
    ady_r           <= ady_nxt;
    transpose_r     <= transpose_nxt;
    a_r             <= a_nxt;
    b_r             <= b_nxt;
    a_end_r         <= a_end_nxt;
    b_end_r         <= b_end_nxt;
    da_r            <= da_nxt;
    db_r            <= db_nxt;
    step_neg_r      <= step_neg_nxt;
    d_r             <= d_nxt;
    inc_step_r      <= inc_step_nxt;
    inc_flat_r      <= inc_flat_nxt;
    left_r          <= left_nxt;
    last_r          <= last_nxt;
    pix_idx_r       <= pix_idx_nxt;
    cnt_r           <= cnt_nxt;
    rd_data_r       <= rd_data_nxt;
    if (!rst_n) begin
      // Start with the clearing pass over the whole store
      state_r     <= S_CLEAR;
      clr_cmd_r   <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrfb_checker.sv =====
// Port-level checks of the line raster framebuffer and their bind.
// Depends on lrfb_pkg; binds into line_raster_framebuffer.
`default_nettype none

module lrfb_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [7:0]           out_read_data,
  input wire lrfb_pkg::cnt_t       out_pixels_drawn
);

  import lrfb_pkg::*;

  // Reset starts the clearing pass: no request is taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during the clearing pass after reset");

  // Reset drops any held result
  a_reset_drops_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // One request at a time: the cycle after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in work");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)
                                  && $stable(out_pixels_drawn)))
    else $error("stalled result changed or vanished");

  // No line covers more points than the coordinate range allows
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixels_drawn <= MAX_PIXELS))
    else $error("pixel count out of range");

endmodule

bind line_raster_framebuffer lrfb_checker u_lrfb_checker (.*);

`default_nettype wire

// ===== dv/tb_line_raster_framebuffer.sv =====
// Self-checking testbench for line_raster_framebuffer: lines, pixels, reads, clears.
// Depends on lrfb_pkg and the block's RTL; it keeps its own shadow of the framebuffer.
`timescale 1ns / 100ps

module tb_line_raster_framebuffer;
  import lrfb_pkg::*;

  localparam int DISP_W      = 320;
  localparam int DISP_H      = 240;
  localparam int STORE_BYTES = (DISP_W * DISP_H + 1) / 2;
  localparam int N_RANDOM    = 1650;
  // Generous cycle ceiling: reset sweep, a handful of full clears, two
  // 65536-point lines and every other request at its worst, several times over.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic [1:0]  kind;
    coord_t      sx;
    coord_t      sy;
    coord_t      ex;
    coord_t      ey;
    logic [3:0]  color;
    logic [15:0] addr;
    bit          drain;   // hold this request back until every result is home
  } fb_cmd_t;

  typedef struct {
    logic [7:0] rd;
    cnt_t       drawn;
  } fb_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_READ;
  coord_t      in_start_x = '0;
  coord_t      in_start_y = '0;
  coord_t      in_end_x = '0;
  coord_t      in_end_y = '0;
  logic [3:0]  in_pixel_color = '0;
  logic [15:0] in_byte_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  cnt_t        out_pixels_drawn;

  // Shadow framebuffer and the bookkeeping between driver and monitor
  logic [7:0] shadow_fb [0:STORE_BYTES-1];
  fb_cmd_t    pending_q[$];
  fb_resp_t   expected_q[$];
  fb_cmd_t    cur_cmd;
  int         n_items = 0;
  int         accepted_cnt = 0;   // NBA only, so both sides see the pre-edge count
  int         results_seen = 0;   // NBA only, same reason
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         n_line = 0, n_pixel = 0, n_read = 0, n_clear = 0;
  int         burst_left = 4;
  int         gap_left = 0;
  int         stall_mode = 0;
  int         stall_timer = 0;

  line_raster_framebuffer #(
    .DISPLAY_WIDTH  (DISP_W),
    .DISPLAY_HEIGHT (DISP_H)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_pixel_color   (in_pixel_color),
    .in_byte_address  (in_byte_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pixels_drawn (out_pixels_drawn)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow framebuffer model
  // ---------------------------------------------------------------------------

  // Write one pixel into the shadow store; drop it if it is off screen.
  function automatic int paint_pixel(longint x, longint y, logic [3:0] col);
    longint idx;
    longint bidx;
    if (x < 0 || y < 0 || x >= DISP_W || y >= DISP_H) return 0;
    idx  = y * DISP_W + x;
    bidx = idx / 2;
    if (bidx >= STORE_BYTES) return 0;
    // even pixel lives in the high nibble, odd pixel in the low one
    if ((idx % 2) == 1)
      shadow_fb[bidx] = (shadow_fb[bidx] & NIB_HI_MASK) | {4'h0, col};
    else
      shadow_fb[bidx] = (shadow_fb[bidx] & NIB_LO_MASK) | {col, 4'h0};
    return 1;
  endfunction

  // Walk the major axis a0..a1 (a0 <= a1) with the minor axis b; when
  // row_major is set, a is the row and b the column.
  function automatic int trace_span(longint a0, longint b0, longint a1, longint b1,
                                    logic [3:0] col, bit row_major);
    longint da, db, stp, d, a, b;
    int     count;
    da    = a1 - a0;
    db    = b1 - b0;
    stp   = 1;
    count = 0;
    if (db < 0) begin
      stp = -1;
      db  = -db;
    end
    d = 2 * db - da;
    b = b0;
    for (a = a0; a <= a1; a++) begin
      count += row_major ? paint_pixel(b, a, col) : paint_pixel(a, b, col);
      if (d > 0) begin
        b += stp;
        d += 2 * (db - da);
      end else begin
        d += 2 * db;
      end
    end
    return count;
  endfunction

  // Pick the major axis (ties go to y) and start from its smaller end.
  function automatic int raster_line(longint x0, longint y0, longint x1, longint y1,
                                     logic [3:0] col);
    longint adx, ady;
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    if (ady < adx) begin
      if (x0 > x1) return trace_span(x1, y1, x0, y0, col, 1'b0);
      return trace_span(x0, y0, x1, y1, col, 1'b0);
    end
    if (y0 > y1) return trace_span(y1, x1, y0, x0, col, 1'b1);
    return trace_span(y0, x0, y1, x1, col, 1'b1);
  endfunction

  // Apply one accepted request to the shadow store and return its result.
  function automatic fb_resp_t apply_cmd(fb_cmd_t c);
    fb_resp_t r;
    r.rd    = '0;
    r.drawn = '0;
    case (c.kind)
      KIND_LINE: begin
        r.drawn = cnt_t'(raster_line(longint'(c.sx), longint'(c.sy),
                                     longint'(c.ex), longint'(c.ey), c.color));
      end
      KIND_PIXEL: begin
        r.drawn = cnt_t'(paint_pixel(longint'(c.sx), longint'(c.sy), c.color));
      end
      KIND_READ: begin
        if (int'(c.addr) < STORE_BYTES) r.rd = shadow_fb[c.addr];
      end
      default: begin
        for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders: every field starts random so unused ones toggle too
  // ---------------------------------------------------------------------------

  function automatic fb_cmd_t noise_cmd();
    fb_cmd_t c;
    c.kind  = 2'($urandom);
    c.sx    = coord_t'($urandom);
    c.sy    = coord_t'($urandom);
    c.ex    = coord_t'($urandom);
    c.ey    = coord_t'($urandom);
    c.color = 4'($urandom);
    c.addr  = 16'($urandom);
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic fb_cmd_t mk_line(int x0, int y0, int x1, int y1, int col);
    fb_cmd_t c;
    c       = noise_cmd();
    c.kind  = KIND_LINE;
    c.sx    = coord_t'(x0);
    c.sy    = coord_t'(y0);
    c.ex    = coord_t'(x1);
    c.ey    = coord_t'(y1);
    c.color = 4'(col);
    return c;
  endfunction

  function automatic fb_cmd_t mk_pixel(int x, int y, int col);
    fb_cmd_t c;
    c       = noise_cmd();
    c.kind  = KIND_PIXEL;
    c.sx    = coord_t'(x);
    c.sy    = coord_t'(y);
    c.color = 4'(col);
    return c;
  endfunction

  function automatic fb_cmd_t mk_read(int a);
    fb_cmd_t c;
    c      = noise_cmd();
    c.kind = KIND_READ;
    c.addr = 16'(a);
    return c;
  endfunction

  function automatic fb_cmd_t mk_clear();
    fb_cmd_t c;
    c      = noise_cmd();
    c.kind = KIND_CLEAR;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present requests in bursts, hold a stalled one, predict on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    logic fire;
    logic load;
    int   acc_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire    = in_valid && !in_stall;
      load    = 1'b0;
      acc_now = accepted_cnt;
      if (fire) begin
        // request taken at this edge: fold it into the shadow store now
        expected_q.push_back(apply_cmd(cur_cmd));
        acc_now++;
        accepted_cnt <= acc_now;
        case (cur_cmd.kind)
          KIND_LINE:  n_line++;
          KIND_PIXEL: n_pixel++;
          KIND_READ:  n_read++;
          default:    n_clear++;
        endcase
      end
      // a stalled request stays put; otherwise decide on the next one
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          // drain marker: wait until every accepted request has its result
          if (!pending_q[0].drain || results_seen == acc_now) begin
            cur_cmd = pending_q.pop_front();
            load    = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 16);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end
        in_valid <= load;
        if (load) begin
          in_kind         <= cur_cmd.kind;
          in_start_x      <= cur_cmd.sx;
          in_start_y      <= cur_cmd.sy;
          in_end_x        <= cur_cmd.ex;
          in_end_y        <= cur_cmd.ey;
          in_pixel_color  <= cur_cmd.color;
          in_byte_address <= cur_cmd.addr;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, and
  // stall the result channel in modes that are picked anew whenever a random
  // timer runs out
  always @(posedge clk) begin : watch_proc
    fb_resp_t want;
    logic     nxt_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_seen >= accepted_cnt) begin
          $error("result with no request pending: read_data %0h pixels_drawn %0d",
                 out_read_data, out_pixels_drawn);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_read_data !== want.rd) begin
            $error("read_data mismatch: expected %0h, actual %0h", want.rd, out_read_data);
            err_cnt++;
          end
          if (out_pixels_drawn !== want.drawn) begin
            $error("pixels_drawn mismatch: expected %0d, actual %0d",
                   want.drawn, out_pixels_drawn);
            err_cnt++;
          end
          results_seen <= results_seen + 1;
        end
      end
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(40, 600);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       nxt_stall = 1'b0;                          // free flowing
        1:       nxt_stall = ($urandom_range(0, 3) == 0);   // light, scattered
        2:       nxt_stall = ($urandom_range(0, 3) != 0);   // heavy, scattered
        default: nxt_stall = ((stall_timer % 37) < 25);     // long blocks
      endcase
      out_stall <= nxt_stall;
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("line_raster_framebuffer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    fb_cmd_t c;
    int      hot_q[$];
    int      x0, y0, x1, y1;
    int      sel, pick;
    int      clears_left;

    for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;

    // Directed: nibble packing, corners, clipping, both major axes in both minor directions, extremes
    pending_q.push_back(mk_read(0));
    pending_q.push_back(mk_pixel(0, 0, 15));
    pending_q.push_back(mk_pixel(1, 0, 10));
    pending_q.push_back(mk_read(0));
    pending_q.push_back(mk_pixel(DISP_W - 1, DISP_H - 1, 5));
    pending_q.push_back(mk_read(STORE_BYTES - 1));
    pending_q.push_back(mk_pixel(-1, 0, 3));
    pending_q.push_back(mk_pixel(DISP_W, 7, 3));
    pending_q.push_back(mk_pixel(7, DISP_H, 3));
    pending_q.push_back(mk_pixel(-32768, 32767, 9));
    pending_q.push_back(mk_pixel(32767, -32768, 9));
    pending_q.push_back(mk_line(-5, 10, DISP_W + 10, 10, 3));     // clipped both ends
    pending_q.push_back(mk_line(20, DISP_H + 10, 20, -10, 12));   // vertical, reversed
    pending_q.push_back(mk_line(40, 40, 100, 60, 1));             // shallow, rising
    pending_q.push_back(mk_line(100, 90, 40, 100, 2));            // shallow, swapped
    pending_q.push_back(mk_line(60, 20, 70, 90, 4));              // steep
    pending_q.push_back(mk_line(80, 90, 70, 20, 6));              // steep, swapped
    pending_q.push_back(mk_line(10, 200, 60, 150, 8));            // equal spans
    pending_q.push_back(mk_line(50, 50, 50, 50, 0));              // single point
    pending_q.push_back(mk_line(-32768, -32768, 32767, 32767, 7));
    pending_q.push_back(mk_line(-32768, 100, 32767, 100, 11));
    c = mk_read((10 * DISP_W + 20) / 2);
    c.drain = 1'b1;
    pending_q.push_back(c);
    pending_q.push_back(mk_read(STORE_BYTES));                    // just past the store
    pending_q.push_back(mk_read(16'hffff));
    pending_q.push_back(mk_clear());
    c = mk_read(0);
    c.drain = 1'b1;
    pending_q.push_back(c);
    pending_q.push_back(mk_pixel(2, 0, 15));

    // Random: mostly near-screen geometry so lines stay short, reads often aimed at
    // bytes that were recently painted, and a few full clears
    clears_left = 3;
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 199);
      if (sel < 76) begin
        x0 = int'($urandom_range(0, DISP_W + 47)) - 24;
        y0 = int'($urandom_range(0, DISP_H + 47)) - 24;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          x1 = x0 + int'($urandom_range(0, 96)) - 48;
          y1 = y0 + int'($urandom_range(0, 96)) - 48;
        end else if (pick == 14) begin
          x1 = x0;
          y1 = y0;
        end else begin
          x1 = int'($urandom_range(0, DISP_W + 47)) - 24;
          y1 = int'($urandom_range(0, DISP_H + 47)) - 24;
        end
        c = mk_line(x0, y0, x1, y1, $urandom_range(0, 15));
        if (x0 >= 0 && y0 >= 0 && x0 < DISP_W && y0 < DISP_H)
          hot_q.push_back((y0 * DISP_W + x0) / 2);
      end else if (sel < 126) begin
        x0 = int'($urandom_range(0, DISP_W + 7)) - 4;
        y0 = int'($urandom_range(0, DISP_H + 7)) - 4;
        c = mk_pixel(x0, y0, $urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) begin
          // full-range coordinates: nearly always clipped
          c.sx = coord_t'($urandom);
          c.sy = coord_t'($urandom);
        end else if (x0 >= 0 && y0 >= 0 && x0 < DISP_W && y0 < DISP_H) begin
          hot_q.push_back((y0 * DISP_W + x0) / 2);
        end
      end else if (sel < 199 || clears_left == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 10 && hot_q.size() > 0)
          c = mk_read(hot_q[$urandom_range(0, hot_q.size() - 1)]);
        else if (pick < 17)
          c = mk_read($urandom_range(0, STORE_BYTES - 1));
        else
          c = mk_read(16'($urandom));
      end else begin
        c = mk_clear();
        clears_left--;
      end
      while (hot_q.size() > 16) void'(hot_q.pop_front());
      c.drain = ($urandom_range(0, 79) == 0);
      pending_q.push_back(c);
    end
    n_items = pending_q.size();

    // Hold reset, then let the block run its clearing sweep
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != n_items) @(posedge clk);
    while (results_seen != accepted_cnt) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d predicted results never arrived", expected_q.size());
      err_cnt++;
    end

    $display("Covered %0d lines, %0d pixel writes, %0d byte reads and %0d clears;",
             n_line, n_pixel, n_read, n_clear);
    $display("%0d results checked in %0d cycles, %0d errors.",
             results_seen, cycle_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("line_raster_framebuffer regression: pass");
    end else begin
      $display("line_raster_framebuffer regression: fail");
    end
    $finish;
  end

endmodule
